// ----- rtl/csort_pkg.sv -----
// Shared types and codes for the conveyor metal sort controller.
`timescale 1ns / 1ps

package csort_pkg;

  localparam int unsigned HeightW = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EMPTY_LEVEL = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_TOL  = 2'd1;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_STANDBY   = 4'd1,
    ST_READY     = 4'd2,
    ST_TRANSPORT = 4'd3,
    ST_MEASURE   = 4'd4,
    ST_OK        = 4'd5,
    ST_END       = 4'd6,
    ST_BAD       = 4'd7,
    ST_BACK      = 4'd8,
    ST_ERROR     = 4'd9
  } state_t;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_SLOW  = 2'd1,
    DRV_RIGHT = 2'd2,
    DRV_LEFT  = 2'd3
  } drive_t;

  // One sensor snapshot as captured by the input register.
  typedef struct packed {
    logic               start_released;
    logic               item_at_entry;
    logic               item_at_height_sensor;
    logic               item_at_metal_sensor;
    logic               item_at_exit;
    logic [HeightW-1:0] height_sample;
    logic               part_accepted;
    logic               emergency_active;
    logic               second_parity;
  } sample_t;

  // Height comparison results used by the state logic.
  typedef struct packed {
    logic above_tol;
    logic below_tol;
  } height_flags_t;

  // Held actuator and indicator outputs.
  typedef struct packed {
    drive_t drive;
    logic   green;
    logic   yellow;
    logic   red;
    logic   led_start;
    logic   led_q1;
    logic   led_q2;
    logic   led_reset;
    logic   junction;
  } held_t;

endpackage

// ----- rtl/csort_fsm.sv -----
// Next-state logic of the sorting sequence, including the height deviation checks.
`timescale 1ns / 1ps

module csort_fsm (
  input  csort_pkg::state_t                 state,
  input  csort_pkg::sample_t                smp,
  input  logic [csort_pkg::HeightW-1:0]     empty_level,
  input  logic [csort_pkg::HeightW-1:0]     height_tolerance,
  output csort_pkg::state_t                 state_next
);

  logic [csort_pkg::HeightW-1:0] dev;
  csort_pkg::height_flags_t      flags;

  always_comb begin
    if (smp.height_sample >= empty_level) begin
      dev = smp.height_sample - empty_level;
    end else begin
      dev = empty_level - smp.height_sample;
    end
    flags.above_tol = dev > height_tolerance;
    flags.below_tol = dev < height_tolerance;
  end

  // Later checks override earlier ones; error is last.
  always_comb begin
    state_next = state;
    unique case (state)
      csort_pkg::ST_START: begin
        state_next = csort_pkg::ST_STANDBY;
      end
      csort_pkg::ST_STANDBY: begin
        if (smp.start_released) state_next = csort_pkg::ST_READY;
      end
      csort_pkg::ST_READY: begin
        if (smp.start_released) state_next = csort_pkg::ST_STANDBY;
        if (smp.item_at_entry && !smp.item_at_exit) state_next = csort_pkg::ST_TRANSPORT;
        if (smp.item_at_height_sensor || smp.item_at_metal_sensor)
          state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_TRANSPORT: begin
        if (flags.above_tol) state_next = csort_pkg::ST_MEASURE;
        if (smp.item_at_exit || smp.item_at_metal_sensor) state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_MEASURE: begin
        if (flags.below_tol)
          state_next = smp.part_accepted ? csort_pkg::ST_OK : csort_pkg::ST_BAD;
        if (smp.item_at_exit || smp.item_at_metal_sensor) state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_OK: begin
        if (smp.item_at_exit) state_next = csort_pkg::ST_END;
        if (smp.item_at_entry) state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_END: begin
        if (smp.start_released) state_next = csort_pkg::ST_STANDBY;
        if (!smp.item_at_exit) state_next = csort_pkg::ST_READY;
        if (smp.item_at_metal_sensor || smp.item_at_height_sensor)
          state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_BAD: begin
        if (smp.item_at_entry) state_next = csort_pkg::ST_BACK;
        if (smp.item_at_exit || smp.item_at_metal_sensor) state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_BACK: begin
        if (smp.start_released) state_next = csort_pkg::ST_STANDBY;
        if (!smp.item_at_entry) state_next = csort_pkg::ST_READY;
        if (smp.item_at_exit || smp.item_at_height_sensor || smp.item_at_metal_sensor)
          state_next = csort_pkg::ST_ERROR;
      end
      csort_pkg::ST_ERROR: begin
        if (smp.start_released) state_next = csort_pkg::ST_STANDBY;
      end
      default: begin
        state_next = csort_pkg::ST_START;
      end
    endcase
  end

endmodule

// ----- rtl/csort_out.sv -----
// Output update: drive, lamps, LEDs and junction from the new state.
`timescale 1ns / 1ps

module csort_out (
  input  csort_pkg::state_t state_next,
  input  logic              emergency,
  input  logic              blink,
  input  csort_pkg::held_t  held,
  output csort_pkg::held_t  held_next
);

  always_comb begin
    held_next = held;
    if (emergency) begin
      // Machine keeps stepping; actuators safe, red blinks, LEDs untouched.
      held_next.drive    = csort_pkg::DRV_STOP;
      held_next.green    = 1'b0;
      held_next.yellow   = 1'b0;
      held_next.red      = blink;
      held_next.junction = 1'b0;
    end else begin
      case (state_next) inside
        csort_pkg::ST_START, csort_pkg::ST_STANDBY: begin
          held_next.drive     = csort_pkg::DRV_STOP;
          held_next.green     = 1'b0;
          held_next.yellow    = 1'b0;
          held_next.red       = 1'b0;
          held_next.led_start = 1'b1;
          held_next.led_q1    = 1'b0;
          held_next.led_q2    = 1'b0;
          held_next.led_reset = 1'b0;
        end
        csort_pkg::ST_READY: begin
          held_next.drive     = csort_pkg::DRV_STOP;
          held_next.green     = 1'b1;
          held_next.yellow    = 1'b0;
          held_next.red       = 1'b0;
          held_next.led_start = 1'b1;
        end
        csort_pkg::ST_TRANSPORT: begin
          held_next.drive     = csort_pkg::DRV_SLOW;
          held_next.green     = 1'b1;
          held_next.yellow    = 1'b0;
          held_next.red       = 1'b0;
          held_next.led_start = 1'b0;
        end
        csort_pkg::ST_MEASURE: begin
          held_next.drive  = csort_pkg::DRV_SLOW;
          held_next.green  = 1'b1;
          held_next.yellow = 1'b0;
          held_next.red    = 1'b0;
        end
        csort_pkg::ST_OK: begin
          held_next.drive     = csort_pkg::DRV_RIGHT;
          held_next.green     = 1'b1;
          held_next.yellow    = 1'b0;
          held_next.red       = 1'b0;
          held_next.led_start = 1'b0;
          held_next.junction  = 1'b1;
        end
        csort_pkg::ST_END: begin
          held_next.drive     = csort_pkg::DRV_STOP;
          held_next.green     = blink;
          held_next.yellow    = 1'b0;
          held_next.red       = 1'b0;
          held_next.junction  = 1'b0;
          held_next.led_start = 1'b1;
        end
        csort_pkg::ST_BAD: begin
          held_next.drive  = csort_pkg::DRV_LEFT;
          held_next.green  = 1'b0;
          held_next.yellow = 1'b1;
          held_next.red    = 1'b0;
        end
        csort_pkg::ST_BACK: begin
          held_next.drive     = csort_pkg::DRV_STOP;
          held_next.green     = 1'b0;
          held_next.yellow    = blink;
          held_next.red       = 1'b0;
          held_next.led_start = 1'b1;
        end
        default: begin
          // error
          held_next.drive     = csort_pkg::DRV_STOP;
          held_next.green     = 1'b0;
          held_next.yellow    = 1'b0;
          held_next.red       = blink;
          held_next.led_start = 1'b1;
          held_next.junction  = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/conveyor_metal_sort_controller.sv -----
// Top level of the conveyor metal sort controller: handshakes, registers, config.
`timescale 1ns / 1ps

// Conveyor metal sort controller. Every input beat is one control tick: a
// snapshot of the belt sensors, the start-release pulse, the emergency button,
// a height sample, the metal verdict and the seconds parity bit. Each tick
// yields exactly one output beat carrying the held drive mode, lamps, LEDs,
// junction and the new state code (0 start .. 9 error). A beat lands in the
// input register, the combinational next-state and output logic runs from it,
// and the result register doubles as the held-output state. A beat passes
// through the input register and then the result register; throughput is one
// beat per cycle while the output side does not stall. in_stall rises only
// when both registers are full and the output side stalls. Belt height and
// height tolerance are written through the cfg port (index 0 and 1); the user
// must write them only while the block is idle, which the block itself does not
// enforce. Reset values are 3600 and 100. Other indexes are ignored. A height
// deviation exactly equal to the tolerance neither starts nor ends a
// measurement. Emergency stops the drive, closes the junction, blanks green
// and yellow and blinks red with second_parity; the machine keeps stepping.

module conveyor_metal_sort_controller (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_released,
  input  logic        item_at_entry,
  input  logic        item_at_height_sensor,
  input  logic        item_at_metal_sensor,
  input  logic        item_at_exit,
  input  logic [11:0] height_sample,
  input  logic        part_accepted,
  input  logic        emergency_active,
  input  logic        second_parity,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  drive_mode,
  output logic        light_green,
  output logic        light_yellow,
  output logic        light_red,
  output logic        led_start,
  output logic        led_q1,
  output logic        led_q2,
  output logic        led_reset,
  output logic        junction_open,
  output logic [3:0]  state_code,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [11:0] EMPTY_LEVEL_RST = 12'd3600;
  localparam logic [11:0] HEIGHT_TOL_RST  = 12'd100;

  csort_pkg::sample_t       smp;
  logic                     smp_valid;
  csort_pkg::state_t        state;
  csort_pkg::state_t        state_next;
  csort_pkg::held_t         held;
  csort_pkg::held_t         held_next;
  logic [11:0]              empty_level;
  logic [11:0]              height_tolerance;
  logic                     advance;
  logic                     in_take;
  logic                     cfg_take;

  // A sample is held and the result slot is free or being drained this cycle.
  assign advance  = smp_valid && (!out_valid || !out_stall);
  assign in_stall = smp_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  csort_fsm u_fsm (
    .state            (state),
    .smp              (smp),
    .empty_level      (empty_level),
    .height_tolerance (height_tolerance),
    .state_next       (state_next)
  );

  csort_out u_out (
    .state_next (state_next),
    .emergency  (smp.emergency_active),
    .blink      (smp.second_parity),
    .held       (held),
    .held_next  (held_next)
  );

  // Input payload register; no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp.start_released        <= start_released;
      smp.item_at_entry         <= item_at_entry;
      smp.item_at_height_sensor <= item_at_height_sensor;
      smp.item_at_metal_sensor  <= item_at_metal_sensor;
      smp.item_at_exit          <= item_at_exit;
      smp.height_sample         <= height_sample;
      smp.part_accepted         <= part_accepted;
      smp.emergency_active      <= emergency_active;
      smp.second_parity         <= second_parity;
    end
  end

  // Control, machine state, held outputs and config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid        <= 1'b0;
      out_valid        <= 1'b0;
      state            <= csort_pkg::ST_START;
      held             <= '0;
      empty_level      <= EMPTY_LEVEL_RST;
      height_tolerance <= HEIGHT_TOL_RST;
    end else begin
      if (in_take) begin
        smp_valid <= 1'b1;
      end else if (advance) begin
        smp_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
        held      <= held_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_take) begin
        unique case (cfg_index)
          csort_pkg::CFG_EMPTY_LEVEL: empty_level      <= cfg_data;
          csort_pkg::CFG_HEIGHT_TOL:  height_tolerance <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign drive_mode    = held.drive;
  assign light_green   = held.green;
  assign light_yellow  = held.yellow;
  assign light_red     = held.red;
  assign led_start     = held.led_start;
  assign led_q1        = held.led_q1;
  assign led_q2        = held.led_q2;
  assign led_reset     = held.led_reset;
  assign junction_open = held.junction;
  assign state_code    = state;

endmodule

// ----- dv/conveyor_metal_sort_controller_tb.sv -----
// Self-checking testbench for the conveyor metal sort controller.
`timescale 1ns / 1ps

module conveyor_metal_sort_controller_tb;

  localparam int REG_COUNT = 2;   // indexes at or above this are ignored by the block
  localparam int REG_LAST  = 3;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 280;
  localparam int SHOW_MAX  = 10;

  // Everything one output beat carries.
  typedef struct packed {
    csort_pkg::held_t  held;
    csort_pkg::state_t st;
  } sort_result_t;

  // Tracks the sorting machine: predicts each tick's outputs and checks them.
  class sort_tracker;
    logic [11:0]       belt_level;
    logic [11:0]       tol_level;
    csort_pkg::state_t cur_state;
    csort_pkg::held_t  held;
    sort_result_t      expected_outs[$];
    int                fail_count;
    int                shown;

    function new();
      belt_level = 12'd3600;
      tol_level  = 12'd100;
      cur_state  = csort_pkg::ST_START;
      held       = '0;
      fail_count = 0;
      shown      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] v);
      if (idx == csort_pkg::CFG_EMPTY_LEVEL) begin
        belt_level = v;
      end else if (idx == csort_pkg::CFG_HEIGHT_TOL) begin
        tol_level = v;
      end
    endfunction

    function void set_lamps(logic g, logic y, logic r);
      held.green  = g;
      held.yellow = y;
      held.red    = r;
    endfunction

    // One accepted input beat: step the machine, update held outputs.
    function void note_tick(csort_pkg::sample_t s);
      int                dev;
      csort_pkg::state_t nx;
      sort_result_t      res;
      dev = (s.height_sample >= belt_level) ? int'(s.height_sample) - int'(belt_level)
                                            : int'(belt_level) - int'(s.height_sample);
      nx = cur_state;
      // later checks override earlier ones, error last
      case (cur_state)
        csort_pkg::ST_START: nx = csort_pkg::ST_STANDBY;
        csort_pkg::ST_STANDBY: if (s.start_released) nx = csort_pkg::ST_READY;
        csort_pkg::ST_READY: begin
          if (s.start_released) nx = csort_pkg::ST_STANDBY;
          if (s.item_at_entry && !s.item_at_exit) nx = csort_pkg::ST_TRANSPORT;
          if (s.item_at_height_sensor || s.item_at_metal_sensor) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_TRANSPORT: begin
          if (dev > int'(tol_level)) nx = csort_pkg::ST_MEASURE;
          if (s.item_at_exit || s.item_at_metal_sensor) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_MEASURE: begin
          if (dev < int'(tol_level)) nx = s.part_accepted ? csort_pkg::ST_OK : csort_pkg::ST_BAD;
          if (s.item_at_exit || s.item_at_metal_sensor) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_OK: begin
          if (s.item_at_exit) nx = csort_pkg::ST_END;
          if (s.item_at_entry) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_END: begin
          if (s.start_released) nx = csort_pkg::ST_STANDBY;
          if (!s.item_at_exit) nx = csort_pkg::ST_READY;
          if (s.item_at_metal_sensor || s.item_at_height_sensor) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_BAD: begin
          if (s.item_at_entry) nx = csort_pkg::ST_BACK;
          if (s.item_at_exit || s.item_at_metal_sensor) nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_BACK: begin
          if (s.start_released) nx = csort_pkg::ST_STANDBY;
          if (!s.item_at_entry) nx = csort_pkg::ST_READY;
          if (s.item_at_exit || s.item_at_height_sensor || s.item_at_metal_sensor)
            nx = csort_pkg::ST_ERROR;
        end
        csort_pkg::ST_ERROR: if (s.start_released) nx = csort_pkg::ST_STANDBY;
        default: nx = csort_pkg::ST_START;
      endcase
      cur_state = nx;

      if (s.emergency_active) begin
        // machine steps on, actuators go safe, LEDs hold
        held.drive    = csort_pkg::DRV_STOP;
        held.junction = 1'b0;
        set_lamps(1'b0, 1'b0, s.second_parity);
      end else begin
        case (nx) inside
          csort_pkg::ST_START, csort_pkg::ST_STANDBY: begin
            held.drive = csort_pkg::DRV_STOP;
            set_lamps(1'b0, 1'b0, 1'b0);
            held.led_start = 1'b1;
            held.led_q1    = 1'b0;
            held.led_q2    = 1'b0;
            held.led_reset = 1'b0;
          end
          csort_pkg::ST_READY: begin
            held.drive = csort_pkg::DRV_STOP;
            set_lamps(1'b1, 1'b0, 1'b0);
            held.led_start = 1'b1;
          end
          csort_pkg::ST_TRANSPORT: begin
            held.drive = csort_pkg::DRV_SLOW;
            set_lamps(1'b1, 1'b0, 1'b0);
            held.led_start = 1'b0;
          end
          csort_pkg::ST_MEASURE: begin
            held.drive = csort_pkg::DRV_SLOW;
            set_lamps(1'b1, 1'b0, 1'b0);
          end
          csort_pkg::ST_OK: begin
            held.drive = csort_pkg::DRV_RIGHT;
            set_lamps(1'b1, 1'b0, 1'b0);
            held.led_start = 1'b0;
            held.junction  = 1'b1;
          end
          csort_pkg::ST_END: begin
            held.drive = csort_pkg::DRV_STOP;
            set_lamps(s.second_parity, 1'b0, 1'b0);
            held.junction  = 1'b0;
            held.led_start = 1'b1;
          end
          csort_pkg::ST_BAD: begin
            held.drive = csort_pkg::DRV_LEFT;
            set_lamps(1'b0, 1'b1, 1'b0);
          end
          csort_pkg::ST_BACK: begin
            held.drive = csort_pkg::DRV_STOP;
            set_lamps(1'b0, s.second_parity, 1'b0);
            held.led_start = 1'b1;
          end
          default: begin
            held.drive = csort_pkg::DRV_STOP;
            set_lamps(1'b0, 1'b0, s.second_parity);
            held.led_start = 1'b1;
            held.junction  = 1'b0;
          end
        endcase
      end
      res.held = held;
      res.st   = nx;
      expected_outs.push_back(res);
    endfunction

    // One accepted output beat against the oldest expectation.
    function void check_outputs(sort_result_t got);
      sort_result_t exp_r;
      logic [3:0]   e [10];
      logic [3:0]   g [10];
      string        names [10];
      string        msg;
      if (expected_outs.size() == 0) begin
        fail_count++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("%0t: output beat with nothing expected, state_code %0d", $realtime, got.st);
        end
        return;
      end
      exp_r = expected_outs.pop_front();
      names = '{"drive_mode", "light_green", "light_yellow", "light_red", "led_start",
                "led_q1", "led_q2", "led_reset", "junction_open", "state_code"};
      e = '{exp_r.held.drive, exp_r.held.green, exp_r.held.yellow, exp_r.held.red,
            exp_r.held.led_start, exp_r.held.led_q1, exp_r.held.led_q2,
            exp_r.held.led_reset, exp_r.held.junction, exp_r.st};
      g = '{got.held.drive, got.held.green, got.held.yellow, got.held.red,
            got.held.led_start, got.held.led_q1, got.held.led_q2,
            got.held.led_reset, got.held.junction, got.st};
      msg = "";
      foreach (e[i]) begin
        if (g[i] !== e[i]) msg = {msg, $sformatf(" %s exp %0d got %0d", names[i], e[i], g[i])};
      end
      if (msg != "") begin
        fail_count++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("%0t: mismatch:%s", $realtime, msg);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  csort_pkg::sample_t tick_q = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         drive_mode;
  logic               light_green, light_yellow, light_red;
  logic               led_start, led_q1, led_q2, led_reset;
  logic               junction_open;
  logic [3:0]         state_code;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [11:0]        cfg_data = '0;

  sort_tracker tracker;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  always #5 clk = ~clk;

  conveyor_metal_sort_controller i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .start_released        (tick_q.start_released),
    .item_at_entry         (tick_q.item_at_entry),
    .item_at_height_sensor (tick_q.item_at_height_sensor),
    .item_at_metal_sensor  (tick_q.item_at_metal_sensor),
    .item_at_exit          (tick_q.item_at_exit),
    .height_sample         (tick_q.height_sample),
    .part_accepted         (tick_q.part_accepted),
    .emergency_active      (tick_q.emergency_active),
    .second_parity         (tick_q.second_parity),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .drive_mode            (drive_mode),
    .light_green           (light_green),
    .light_yellow          (light_yellow),
    .light_red             (light_red),
    .led_start             (led_start),
    .led_q1                (led_q1),
    .led_q2                (led_q2),
    .led_reset             (led_reset),
    .junction_open         (junction_open),
    .state_code            (state_code),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Random output-side stall bursts while idle_on is set.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    out_stall <= (stall_left != 0);
  end

  // Handshakes sampled mid-cycle, where every signal has settled; a beat seen
  // here is taken by the block at the next rising edge.
  always @(negedge clk) begin
    sort_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_tick(tick_q);
      if (out_valid && !out_stall) begin
        got.held.drive     = csort_pkg::drive_t'(drive_mode);
        got.held.green     = light_green;
        got.held.yellow    = light_yellow;
        got.held.red       = light_red;
        got.held.led_start = led_start;
        got.held.led_q1    = led_q1;
        got.held.led_q2    = led_q2;
        got.held.led_reset = led_reset;
        got.held.junction  = junction_open;
        got.st             = csort_pkg::state_t'(state_code);
        tracker.check_outputs(got);
      end
    end
  end

  function automatic csort_pkg::sample_t snap(bit rel, bit entry, bit hs, bit metal,
                                              bit at_exit, int h, bit good, bit emg,
                                              bit par);
    csort_pkg::sample_t s;
    s.start_released        = rel;
    s.item_at_entry         = entry;
    s.item_at_height_sensor = hs;
    s.item_at_metal_sensor  = metal;
    s.item_at_exit          = at_exit;
    s.height_sample         = h[11:0];
    s.part_accepted         = good;
    s.emergency_active      = emg;
    s.second_parity         = par;
    return s;
  endfunction

  // Height at a given distance from the belt level, random side; falls back to
  // the other side, then to anything, when off the 12-bit scale.
  function automatic logic [11:0] off_belt(int gap);
    int b;
    int h;
    b = int'(tracker.belt_level);
    h = ($urandom_range(0, 1) != 0) ? b + gap : b - gap;
    if (h < 0 || h > 4095) h = (h == b + gap) ? b - gap : b + gap;
    if (h < 0 || h > 4095) h = $urandom_range(0, 4095);
    return h[11:0];
  endfunction

  // Height seen as a part (far) or as empty belt (near), with the exact
  // tolerance boundary and fully random heights mixed in.
  function automatic logic [11:0] pick_height(bit far);
    int t;
    t = int'(tracker.tol_level);
    case ($urandom_range(0, 9)) inside
      0, 1: return off_belt(t);
      2:    return 12'($urandom_range(0, 4095));
      default: begin
        if (far) return off_belt(t + 1 + $urandom_range(0, 300));
        if (t == 0) return off_belt(0);
        return off_belt($urandom_range(0, t - 1));
      end
    endcase
  endfunction

  // Mostly inputs that move a part along the belt from the current state;
  // the rest is raw noise.
  function automatic csort_pkg::sample_t make_tick();
    csort_pkg::sample_t s;
    s = csort_pkg::sample_t'($urandom);
    if ($urandom_range(0, 9) < 2) return s;
    s.start_released        = 1'b0;
    s.item_at_entry         = 1'b0;
    s.item_at_height_sensor = 1'b0;
    s.item_at_metal_sensor  = 1'b0;
    s.item_at_exit          = 1'b0;
    s.emergency_active      = ($urandom_range(0, 19) == 0);
    case (tracker.cur_state) inside
      csort_pkg::ST_STANDBY, csort_pkg::ST_ERROR:
        s.start_released = ($urandom_range(0, 2) != 0);
      csort_pkg::ST_READY: begin
        s.item_at_entry  = ($urandom_range(0, 3) != 0);
        s.start_released = ($urandom_range(0, 7) == 0);
      end
      csort_pkg::ST_TRANSPORT: begin
        s.height_sample         = pick_height($urandom_range(0, 2) != 0);
        s.item_at_height_sensor = ($urandom_range(0, 1) != 0);
        s.item_at_entry         = ($urandom_range(0, 1) != 0);
      end
      csort_pkg::ST_MEASURE: begin
        s.height_sample         = pick_height($urandom_range(0, 2) == 0);
        s.item_at_height_sensor = ($urandom_range(0, 1) != 0);
      end
      csort_pkg::ST_OK: s.item_at_exit = ($urandom_range(0, 2) != 0);
      csort_pkg::ST_END: begin
        s.item_at_exit   = ($urandom_range(0, 3) == 0);
        s.start_released = ($urandom_range(0, 3) == 0);
      end
      csort_pkg::ST_BAD: s.item_at_entry = ($urandom_range(0, 2) != 0);
      csort_pkg::ST_BACK: begin
        s.item_at_entry  = ($urandom_range(0, 3) == 0);
        s.start_released = ($urandom_range(0, 3) == 0);
      end
      default: ;
    endcase
    return s;
  endfunction

  // One input beat, with an occasional idle burst ahead of it.
  task automatic send_tick(csort_pkg::sample_t s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_q   <= s;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // One register write; cfg_valid drops after it and the channel idles before returning.
  task automatic write_reg(logic [1:0] idx, logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Stop sending and let every expected beat come back before returning.
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (tracker.expected_outs.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    csort_pkg::sample_t plan[$];
    int                 belt_set [PHASES];
    int                 tol_set [PHASES];
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk at reset settings (belt 3600, tolerance 100): both release
    // toggles, the exact-tolerance holds on both sides, a good and a bad part,
    // blinking in both phases, error, emergency, and all-ones / all-zeros beats.
    plan.push_back(snap(0, 0, 0, 0, 0, 0,    0, 0, 0));  // start -> standby
    plan.push_back(snap(1, 0, 0, 0, 0, 3600, 0, 0, 0));  // -> ready
    plan.push_back(snap(1, 0, 0, 0, 0, 3600, 0, 0, 0));  // -> standby
    plan.push_back(snap(1, 0, 0, 0, 0, 3600, 0, 0, 1));  // -> ready
    plan.push_back(snap(0, 1, 0, 0, 0, 3600, 0, 0, 0));  // -> transport
    plan.push_back(snap(0, 0, 1, 0, 0, 3700, 0, 0, 0));  // deviation == tol, holds
    plan.push_back(snap(0, 0, 1, 0, 0, 3701, 0, 0, 0));  // -> measure
    plan.push_back(snap(0, 0, 1, 0, 0, 3500, 1, 0, 0));  // deviation == tol, holds
    plan.push_back(snap(0, 0, 0, 0, 0, 3599, 1, 0, 1));  // -> ok
    plan.push_back(snap(0, 0, 0, 0, 1, 3600, 0, 0, 1));  // -> end, green on
    plan.push_back(snap(0, 0, 0, 0, 1, 3600, 0, 0, 0));  // end, green off
    plan.push_back(snap(0, 0, 0, 0, 0, 3600, 0, 0, 0));  // -> ready
    plan.push_back(snap(0, 1, 0, 0, 0, 3600, 0, 0, 0));  // -> transport
    plan.push_back(snap(0, 0, 0, 0, 0, 4095, 0, 0, 0));  // -> measure
    plan.push_back(snap(0, 0, 0, 0, 0, 3600, 0, 0, 0));  // -> bad
    plan.push_back(snap(0, 1, 0, 0, 0, 0,    0, 0, 1));  // -> back
    plan.push_back(snap(0, 0, 0, 0, 0, 0,    0, 0, 0));  // -> ready
    plan.push_back(snap(0, 0, 1, 0, 0, 3600, 0, 0, 1));  // -> error
    plan.push_back(snap(1, 0, 0, 0, 0, 3600, 0, 1, 1));  // -> standby under emergency
    plan.push_back(snap(0, 0, 0, 0, 0, 3600, 0, 1, 0));  // emergency, red off
    plan.push_back(snap(1, 1, 1, 1, 1, 4095, 1, 1, 1));  // all ones
    plan.push_back(snap(1, 1, 1, 1, 1, 4095, 1, 0, 1));  // ready -> error
    plan.push_back(snap(0, 0, 0, 0, 0, 0,    0, 0, 0));  // error holds
    foreach (plan[i]) send_tick(plan[i]);

    // Belt / tolerance settings per phase; the first keeps reset values.
    belt_set = '{3600, 0, 4095, 2048, $urandom_range(0, 4095), 1000};
    tol_set  = '{100, 0, 4095, 50, $urandom_range(0, 400), 300};
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        if ($urandom_range(0, 1) != 0) begin
          write_reg(csort_pkg::CFG_EMPTY_LEVEL, 12'(belt_set[p]));
          write_reg(csort_pkg::CFG_HEIGHT_TOL, 12'(tol_set[p]));
        end else begin
          write_reg(csort_pkg::CFG_HEIGHT_TOL, 12'(tol_set[p]));
          write_reg(csort_pkg::CFG_EMPTY_LEVEL, 12'(belt_set[p]));
        end
        write_reg(2'($urandom_range(REG_COUNT, REG_LAST)), 12'($urandom_range(0, 4095)));
      end
      idle_on = (p != PHASES - 1);   // final phase runs at full rate
      repeat (PHASE_LEN) send_tick(make_tick());
    end

    drain();
    if (tracker.expected_outs.size() != 0) begin
      tracker.fail_count += tracker.expected_outs.size();
      $display("%0t: %0d output beats never arrived", $realtime,
               tracker.expected_outs.size());
    end
    if (tracker.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $realtime);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csort_pkg.sv
rtl/csort_fsm.sv
rtl/csort_out.sv
rtl/conveyor_metal_sort_controller.sv
dv/conveyor_metal_sort_controller_tb.sv
